// File: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared constants for the cartesian to polar converter
// Fixed field widths, angle constants in Q3.13, gain correction and the
// arctangent lookup used by the vectoring cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

  // default configuration
  localparam int unsigned ITERATIONS_DEF = 14;
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned ITERATIONS_MAX = 15;

  // fixed field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned RADIUS_W = 15;
  localparam int unsigned ANGLE_W  = 16;

  // angle constants, signed Q3.13
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

  // gain correction 0.607 as unsigned Q0.16, plus rounding half
  localparam logic [15:0] GAIN_Q16   = 16'd39780;
  localparam int unsigned ROUND_HALF = 32768;
  localparam int unsigned GAIN_SHIFT = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 15'd32767;

  // atan(2^-i) in Q3.13, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q13(input int unsigned idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      0:       val = 16'sd6434;
      1:       val = 16'sd3798;
      2:       val = 16'sd2007;
      3:       val = 16'sd1019;
      4:       val = 16'sd511;
      5:       val = 16'sd256;
      6:       val = 16'sd128;
      7:       val = 16'sd64;
      8:       val = 16'sd32;
      9:       val = 16'sd16;
      10:      val = 16'sd8;
      11:      val = 16'sd4;
      12:      val = 16'sd2;
      13:      val = 16'sd1;
      default: val = 16'sd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ccp_prerot.sv
// ----------------------------------------------------------------------------
// ccp_prerot: quarter-turn pre-rotation stage
// Wraps the input point to the working width and turns points in the left
// half-plane (x <= 0) into the right one, seeding the angle at +/- pi/2.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_prerot #(
  parameter int unsigned DATA_W = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [ccp_pkg::IN_W-1:0]       x_in_i,
  input  logic signed [ccp_pkg::IN_W-1:0]       y_in_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic signed [DATA_W-1:0]              x_o,
  output logic signed [DATA_W-1:0]              y_o,
  output logic signed [ccp_pkg::ANGLE_W-1:0]    ang_o
);
  import ccp_pkg::*;

  logic                      valid_q;
  logic                      advance;
  logic signed [DATA_W-1:0]  x_w, y_w;
  logic                      x_le0, y_gt0;
  logic signed [DATA_W-1:0]  x_d, y_d, x_q, y_q;
  logic signed [ANGLE_W-1:0] ang_d, ang_q;

  // wrap the 16-bit inputs to the working width
  assign x_w   = DATA_W'(x_in_i);
  assign y_w   = DATA_W'(y_in_i);
  assign x_le0 = x_w[DATA_W-1] || (x_w == '0);
  assign y_gt0 = !y_w[DATA_W-1] && (y_w != '0);

  // quarter turn into the right half-plane
  always_comb begin
    if (x_le0 && y_gt0) begin
      x_d   = y_w;
      y_d   = -x_w;
      ang_d = HALF_PI_Q13;
    end else if (x_le0) begin
      x_d   = -y_w;
      y_d   = x_w;
      ang_d = -HALF_PI_Q13;
    end else begin
      x_d   = x_w;
      y_d   = y_w;
      ang_d = '0;
    end
  end

  // stage handshake
  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && advance) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;

endmodule

`default_nettype wire

// File: rtl/ccp_cell.sv
// ----------------------------------------------------------------------------
// ccp_cell: one vectoring micro-rotation
// Rotates the point by +/- atan(2^-STEP) towards the x axis using arithmetic
// shifts and accumulates the matching angle; one registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_cell #(
  parameter int unsigned DATA_W = 18,
  parameter int unsigned STEP   = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [DATA_W-1:0]              x_i,
  input  logic signed [DATA_W-1:0]              y_i,
  input  logic signed [ccp_pkg::ANGLE_W-1:0]    ang_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic signed [DATA_W-1:0]              x_o,
  output logic signed [DATA_W-1:0]              y_o,
  output logic signed [ccp_pkg::ANGLE_W-1:0]    ang_o
);
  import ccp_pkg::*;

  localparam logic signed [ANGLE_W-1:0] ATAN_STEP = atan_q13(STEP);

  logic                      valid_q;
  logic                      advance;
  logic signed [DATA_W-1:0]  xs, ys;
  logic signed [DATA_W-1:0]  x_d, y_d, x_q, y_q;
  logic signed [ANGLE_W-1:0] ang_d, ang_q;

  // shifted cross terms
  assign xs = y_i >>> STEP;
  assign ys = x_i >>> STEP;

  // rotate against the sign of y
  always_comb begin
    if (!y_i[DATA_W-1]) begin
      x_d   = x_i + xs;
      y_d   = y_i - ys;
      ang_d = ang_i + ATAN_STEP;
    end else begin
      x_d   = x_i - xs;
      y_d   = y_i + ys;
      ang_d = ang_i - ATAN_STEP;
    end
  end

  // stage handshake
  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && advance) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;

  // the angle moves by exactly one table step per cell
  a_ang_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> ((ang_q - $past(ang_i)) == ATAN_STEP) ||
                              (($past(ang_i) - ang_q) == ATAN_STEP))
    else $error("cell angle update is not one table step");

endmodule

`default_nettype wire

// File: rtl/ccp_scale.sv
// ----------------------------------------------------------------------------
// ccp_scale: gain correction and output register
// Multiplies the final x by 0.607 in one stage, then rounds and saturates
// the radius and clamps the angle to -pi..pi into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_scale #(
  parameter int unsigned DATA_W = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [DATA_W-1:0]              x_i,
  input  logic signed [ccp_pkg::ANGLE_W-1:0]    ang_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [ccp_pkg::RADIUS_W-1:0]          radius_o,
  output logic signed [ccp_pkg::ANGLE_W-1:0]    angle_o
);
  import ccp_pkg::*;

  localparam int unsigned PW   = DATA_W - 1 + GAIN_SHIFT;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned RF_W = (SW - GAIN_SHIFT > RADIUS_W + 1) ?
                                 (SW - GAIN_SHIFT) : (RADIUS_W + 1);

  logic                      a_valid_q, b_valid_q;
  logic                      a_adv, b_adv;
  logic                      pos_d, pos_q;
  logic [PW-1:0]             prod_d, prod_q;
  logic signed [ANGLE_W-1:0] ang_a_q;
  logic [SW-1:0]             sum;
  logic [RF_W-1:0]           rad_full;
  logic [RADIUS_W-1:0]       radius_d, radius_q;
  logic signed [ANGLE_W-1:0] angle_d, angle_q;

  // stage a: gain multiply of a positive x
  assign pos_d  = !x_i[DATA_W-1] && (x_i != '0);
  assign prod_d = PW'(x_i[DATA_W-2:0]) * PW'(GAIN_Q16);

  assign b_adv   = !b_valid_q || !stall_i;
  assign a_adv   = !a_valid_q || b_adv;
  assign stall_o = !a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (!stall_o) begin
        a_valid_q <= valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      prod_q  <= prod_d;
      pos_q   <= pos_d;
      ang_a_q <= ang_i;
    end
  end

  // stage b: round half up, saturate radius, clamp angle
  assign sum      = SW'(prod_q) + SW'(ROUND_HALF);
  assign rad_full = RF_W'(sum[SW-1:GAIN_SHIFT]);

  always_comb begin
    if (!pos_q) begin
      radius_d = '0;
    end else if (rad_full > RF_W'(RADIUS_MAX)) begin
      radius_d = RADIUS_MAX;
    end else begin
      radius_d = rad_full[RADIUS_W-1:0];
    end
    if (ang_a_q > PI_Q13) begin
      angle_d = PI_Q13;
    end else if (ang_a_q < -PI_Q13) begin
      angle_d = -PI_Q13;
    end else begin
      angle_d = ang_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_adv) begin
      radius_q <= radius_d;
      angle_q  <= angle_d;
    end
  end

  assign valid_o  = b_valid_q;
  assign radius_o = radius_q;
  assign angle_o  = angle_q;

  // a non-positive final x gives a zero radius
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_adv && !pos_q) |=> (radius_q == '0))
    else $error("non-positive x did not give zero radius");

  // stage a only holds when stage b is full and held
  a_hold_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_adv |-> (b_valid_q && stall_i))
    else $error("scale stage held without a stalled output");

endmodule

`default_nettype wire

// File: rtl/cordic_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cordic_cartesian_to_polar: pipelined CORDIC vectoring converter
// Converts a signed Q2.14 point to an unsigned Q1.14 magnitude and a Q3.13 angle
// through a pre-rotation stage, a chain of vectoring cells and a scale stage.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | valid_i, stall_o, x_in_i, y_in_i | in
//   output  | valid_o, stall_i, radius_o, angle_o | out
//
// One item per cycle sustained while the output is not stalled; every stage is one register deep.
// The stages are the pre-rotation, one cell per iteration, the gain multiply
// and the round/saturate output register.
// Reset clears the valid flags only; the pipeline is empty after reset.
// A stall on the output holds only the stages that are full behind it,
// so bubbles still close up and new items are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_cartesian_to_polar #(
  parameter int unsigned ITERATIONS = ccp_pkg::ITERATIONS_DEF,
  parameter int unsigned DATA_WIDTH = ccp_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [ccp_pkg::IN_W-1:0]       x_in_i,
  input  logic signed [ccp_pkg::IN_W-1:0]       y_in_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [ccp_pkg::RADIUS_W-1:0]          radius_o,
  output logic signed [ccp_pkg::ANGLE_W-1:0]    angle_o
);
  import ccp_pkg::*;

  localparam int unsigned CW = DATA_WIDTH + 2;

  logic signed [CW-1:0]      x_c   [ITERATIONS+1];
  logic signed [CW-1:0]      y_c   [ITERATIONS+1];
  logic signed [ANGLE_W-1:0] ang_c [ITERATIONS+1];
  logic                      valid_c [ITERATIONS+1];
  logic                      stall_c [ITERATIONS+1];

  // quarter-turn pre-rotation
  ccp_prerot #(
    .DATA_W (CW)
  ) u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .x_in_i  (x_in_i),
    .y_in_i  (y_in_i),
    .valid_o (valid_c[0]),
    .stall_i (stall_c[0]),
    .x_o     (x_c[0]),
    .y_o     (y_c[0]),
    .ang_o   (ang_c[0])
  );

  // chain of vectoring cells
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ccp_cell #(
      .DATA_W (CW),
      .STEP   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .stall_o (stall_c[g]),
      .x_i     (x_c[g]),
      .y_i     (y_c[g]),
      .ang_i   (ang_c[g]),
      .valid_o (valid_c[g+1]),
      .stall_i (stall_c[g+1]),
      .x_o     (x_c[g+1]),
      .y_o     (y_c[g+1]),
      .ang_o   (ang_c[g+1])
    );
  end

  // gain correction and output register
  ccp_scale #(
    .DATA_W (CW)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_c[ITERATIONS]),
    .stall_o  (stall_c[ITERATIONS]),
    .x_i      (x_c[ITERATIONS]),
    .ang_i    (ang_c[ITERATIONS]),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .radius_o (radius_o),
    .angle_o  (angle_o)
  );

  // the input is only held back by a full pipeline behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while the output is free");

  // a delivered angle lies within -pi..pi
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((angle_o <= PI_Q13) && (angle_o >= -PI_Q13)))
    else $error("angle outside -pi..pi");

endmodule

`default_nettype wire
